// ===== src/lcx_pkg.sv =====
// ----------------------------------------------------------------------------
// lcx_pkg: shared types and constants for the max-range contour extractor
// Field widths, fixed-point constants, result kinds, register indexes and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcx_pkg;

   localparam int MAX_BEAMS_DEF     = 2048;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int RANGE_W    = 17;
   localparam int ANGLE_W    = 19;
   localparam int STEP_W     = 17;
   localparam int ACC_W      = 20;
   localparam int COORD_W    = 18;
   localparam int COUNT_W    = 12;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USED_W = 4 * COORD_W + COUNT_W;

   // CORDIC datapath: mm scaled by 2^14, with headroom for the gain
   localparam int CORDIC_W   = 34;
   localparam int FRAC       = 14;
   localparam int GAIN_W     = 30;
   localparam int GAIN_SHIFT = 30 - FRAC;
   localparam int PROD_W     = RANGE_W + GAIN_W;
   localparam int ATAN_IDX_W = 5;

   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

   localparam logic signed [ACC_W-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [ACC_W-1:0] NEG_PI_Q16  = -20'sd205887;
   localparam logic signed [ACC_W-1:0] TWO_PI_Q16  = 20'sd411774;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [ACC_W-1:0] NEG_HALF_PI = -20'sd102944;

   localparam logic [RANGE_W-1:0] SHORT_RANGE_MM = 17'd100;
   localparam logic [COUNT_W-1:0] RUN_MIN        = 12'd2;
   localparam int                 COUNT_MAX      = 4095;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_POINT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RANGE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_USABLE_RANGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_END   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_ANGLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_STEP   = 3'd5;

   // register reset values
   localparam logic [RANGE_W-1:0]        MAX_RANGE_RST    = 17'd29700;
   localparam logic [RANGE_W-1:0]        USABLE_RANGE_RST = 17'd8000;
   localparam logic signed [ANGLE_W-1:0] WINDOW_START_RST = -19'sd137626;
   localparam logic signed [ANGLE_W-1:0] WINDOW_END_RST   = 19'sd137626;
   localparam logic signed [ANGLE_W-1:0] FIRST_ANGLE_RST  = 19'sd0;
   localparam logic signed [STEP_W-1:0]  ANGLE_STEP_RST   = 17'sd286;

   // arctangent of 2^-i, radians scaled by 2^16
   function automatic logic signed [ACC_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         5'd0:    v = 20'sd51472;
         5'd1:    v = 20'sd30385;
         5'd2:    v = 20'sd16055;
         5'd3:    v = 20'sd8150;
         5'd4:    v = 20'sd4091;
         5'd5:    v = 20'sd2047;
         5'd6:    v = 20'sd1024;
         5'd7:    v = 20'sd512;
         5'd8:    v = 20'sd256;
         5'd9:    v = 20'sd128;
         5'd10:   v = 20'sd64;
         5'd11:   v = 20'sd32;
         5'd12:   v = 20'sd16;
         5'd13:   v = 20'sd8;
         5'd14:   v = 20'sd4;
         5'd15:   v = 20'sd2;
         5'd16:   v = 20'sd1;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

   // clamp a wide coordinate to the output range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CORDIC_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > CORDIC_W'(131071)) begin
         r = 18'sd131071;
      end else if (v < -CORDIC_W'(131072)) begin
         r = -18'sd131072;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/lidar_maxrange_contour_extractor.sv =====
// ----------------------------------------------------------------------------
// lidar_maxrange_contour_extractor: max-range contour extraction from a scan
// Projects max-range beams inside the angle window, groups them into runs,
// reports runs of two or more points as segments and closes each scan.
// ----------------------------------------------------------------------------
// One beam is taken at a time; req_tready is low while a beam is in work.
// A beam that projects waits before its first result for the iterative
// CORDIC unit, which performs one micro-rotation per cycle; a beam that
// projects nothing goes straight to the finish step. Each beam then presents
// its zero to three results one per cycle while rsp_tready is high, and the
// next beam is accepted after the last of them is taken. Result order for
// one beam: point, segment, end of scan. Registers may be written only while
// no beam is in work.
`default_nettype none

module lidar_maxrange_contour_extractor #(
   parameter int MAX_BEAMS     = lcx_pkg::MAX_BEAMS_DEF,
   parameter int CORDIC_STAGES = lcx_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tdata: range_mm [16:0], zero padding above
   input  wire logic [lcx_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic                                 req_tlast,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: x_mm, y_mm, x_end_mm, y_end_mm, point_count, zero padding above
   output logic [lcx_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   // tuser: kind
   output logic [lcx_pkg::KIND_W-1:0]                rsp_tuser,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lcx_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [lcx_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lcx_pkg::*;

   localparam int COUNT_CAP_I = (MAX_BEAMS < COUNT_MAX) ? MAX_BEAMS : COUNT_MAX;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_I);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CORDIC = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   // configuration
   logic [RANGE_W-1:0]         max_range_ff, max_range_in;
   logic [RANGE_W-1:0]         usable_range_ff, usable_range_in;
   logic signed [ANGLE_W-1:0]  window_start_ff, window_start_in;
   logic signed [ANGLE_W-1:0]  window_end_ff, window_end_in;
   logic signed [ANGLE_W-1:0]  first_angle_ff, first_angle_in;
   logic signed [STEP_W-1:0]   angle_step_ff, angle_step_in;

   // scan state
   logic [1:0]                 state_ff, state_in;
   logic signed [ACC_W-1:0]    beam_angle_ff, beam_angle_in;
   logic [COUNT_W-1:0]         run_length_ff, run_length_in;
   logic [COUNT_W-1:0]         points_ff, points_in;
   logic                       scan_starting_ff, scan_starting_in;
   logic signed [COORD_W-1:0]  first_x_ff, first_x_in;
   logic signed [COORD_W-1:0]  first_y_ff, first_y_in;
   logic signed [COORD_W-1:0]  last_x_ff, last_x_in;
   logic signed [COORD_W-1:0]  last_y_ff, last_y_in;
   logic                       hit_ff, hit_in;
   logic                       last_ff, last_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       pend_pt_ff, pend_pt_in;
   logic                       pend_seg_ff, pend_seg_in;
   logic                       pend_end_ff, pend_end_in;

   logic                       req_fire, rsp_fire, csr_fire;
   logic [RANGE_W-1:0]         range_mm;
   logic signed [ACC_W-1:0]    cur_angle;
   logic                       long_range;
   logic                       in_window;
   logic                       hit_now;
   logic                       cordic_done;
   logic signed [COORD_W-1:0]  cordic_x, cordic_y;
   logic [COUNT_W-1:0]         pts_next, run_next;
   logic                       closing;
   logic                       seg_now;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign range_mm   = req_tdata[RANGE_W-1:0];

   // the first beam of a scan starts from the configured angle
   assign cur_angle  = scan_starting_ff ? ACC_W'(first_angle_ff) : beam_angle_ff;
   assign long_range = (range_mm < SHORT_RANGE_MM) || (range_mm >= max_range_ff);
   assign in_window  = (cur_angle > ACC_W'(window_start_ff)) &&
                       (cur_angle < ACC_W'(window_end_ff));
   assign hit_now    = long_range && in_window;

   lcx_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire && hit_now),
      .angle  (cur_angle),
      .radius (usable_range_ff),
      .done   (cordic_done),
      .x_out  (cordic_x),
      .y_out  (cordic_y)
   );

   // bookkeeping for the beam in work
   assign pts_next = (hit_ff && (points_ff < COUNT_CAP)) ? points_ff + 1'b1 : points_ff;
   assign run_next = (hit_ff && (run_length_ff < COUNT_CAP)) ?
                     run_length_ff + 1'b1 : run_length_ff;
   assign closing  = last_ff || (!hit_ff && (run_length_ff != '0));
   assign seg_now  = closing && (run_next >= RUN_MIN);

   always_comb begin
      max_range_in    = max_range_ff;
      usable_range_in = usable_range_ff;
      window_start_in = window_start_ff;
      window_end_in   = window_end_ff;
      first_angle_in  = first_angle_ff;
      angle_step_in   = angle_step_ff;
      if (csr_fire) begin
         unique case (csr_index)
            REG_MAX_RANGE:    max_range_in    = csr_wdata[RANGE_W-1:0];
            REG_USABLE_RANGE: usable_range_in = csr_wdata[RANGE_W-1:0];
            REG_WINDOW_START: window_start_in = csr_wdata[ANGLE_W-1:0];
            REG_WINDOW_END:   window_end_in   = csr_wdata[ANGLE_W-1:0];
            REG_FIRST_ANGLE:  first_angle_in  = csr_wdata[ANGLE_W-1:0];
            REG_ANGLE_STEP:   angle_step_in   = csr_wdata[STEP_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      beam_angle_in    = beam_angle_ff;
      run_length_in    = run_length_ff;
      points_in        = points_ff;
      scan_starting_in = scan_starting_ff;
      first_x_in       = first_x_ff;
      first_y_in       = first_y_ff;
      last_x_in        = last_x_ff;
      last_y_in        = last_y_ff;
      hit_in           = hit_ff;
      last_in          = last_ff;
      count_in         = count_ff;
      pend_pt_in       = pend_pt_ff;
      pend_seg_in      = pend_seg_ff;
      pend_end_in      = pend_end_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               hit_in           = hit_now;
               last_in          = req_tlast;
               scan_starting_in = 1'b0;
               beam_angle_in    = cur_angle + ACC_W'(angle_step_ff);
               state_in         = hit_now ? S_CORDIC : S_FINISH;
            end
         end
         S_CORDIC: begin
            if (cordic_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (hit_ff) begin
               if (run_length_ff == '0) begin
                  first_x_in = cordic_x;
                  first_y_in = cordic_y;
               end
               last_x_in = cordic_x;
               last_y_in = cordic_y;
            end
            count_in      = pts_next;
            points_in     = last_ff ? '0 : pts_next;
            run_length_in = closing ? '0 : run_next;
            if (last_ff) begin
               scan_starting_in = 1'b1;
            end
            pend_pt_in  = hit_ff;
            pend_seg_in = seg_now;
            pend_end_in = last_ff;
            state_in    = (hit_ff || seg_now || last_ff) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (rsp_fire) begin
               // retire the result on show, in point, segment, end order
               if (pend_pt_ff) begin
                  pend_pt_in = 1'b0;
               end else if (pend_seg_ff) begin
                  pend_seg_in = 1'b0;
               end else begin
                  pend_end_in = 1'b0;
               end
               if (rsp_tlast) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result currently on show
   always_comb begin
      logic signed [COORD_W-1:0] ox, oy, oxe, oye;
      if (pend_pt_ff) begin
         rsp_tuser = KIND_POINT;
         ox  = last_x_ff;
         oy  = last_y_ff;
         oxe = '0;
         oye = '0;
      end else if (pend_seg_ff) begin
         rsp_tuser = KIND_SEGMENT;
         ox  = first_x_ff;
         oy  = first_y_ff;
         oxe = last_x_ff;
         oye = last_y_ff;
      end else begin
         rsp_tuser = KIND_END;
         ox  = '0;
         oy  = '0;
         oxe = '0;
         oye = '0;
      end
      rsp_tdata = {(RSP_DATA_W - RSP_USED_W)'(0), count_ff, oye, oxe, oy, ox};
   end

   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tlast  = ({pend_pt_ff, pend_seg_ff, pend_end_ff} == 3'b100) ||
                       ({pend_pt_ff, pend_seg_ff, pend_end_ff} == 3'b010) ||
                       ({pend_pt_ff, pend_seg_ff, pend_end_ff} == 3'b001);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff     <= MAX_RANGE_RST;
         usable_range_ff  <= USABLE_RANGE_RST;
         window_start_ff  <= WINDOW_START_RST;
         window_end_ff    <= WINDOW_END_RST;
         first_angle_ff   <= FIRST_ANGLE_RST;
         angle_step_ff    <= ANGLE_STEP_RST;
         state_ff         <= S_IDLE;
         beam_angle_ff    <= '0;
         run_length_ff    <= '0;
         points_ff        <= '0;
         scan_starting_ff <= 1'b1;
         first_x_ff       <= '0;
         first_y_ff       <= '0;
         last_x_ff        <= '0;
         last_y_ff        <= '0;
         pend_pt_ff       <= 1'b0;
         pend_seg_ff      <= 1'b0;
         pend_end_ff      <= 1'b0;
      end else begin
         max_range_ff     <= max_range_in;
         usable_range_ff  <= usable_range_in;
         window_start_ff  <= window_start_in;
         window_end_ff    <= window_end_in;
         first_angle_ff   <= first_angle_in;
         angle_step_ff    <= angle_step_in;
         state_ff         <= state_in;
         beam_angle_ff    <= beam_angle_in;
         run_length_ff    <= run_length_in;
         points_ff        <= points_in;
         scan_starting_ff <= scan_starting_in;
         first_x_ff       <= first_x_in;
         first_y_ff       <= first_y_in;
         last_x_ff        <= last_x_in;
         last_y_ff        <= last_y_in;
         pend_pt_ff       <= pend_pt_in;
         pend_seg_ff      <= pend_seg_in;
         pend_end_ff      <= pend_end_in;
      end
      hit_ff   <= hit_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

// ===== src/lcx_cordic.sv =====
// ----------------------------------------------------------------------------
// lcx_cordic: iterative rotation-mode CORDIC for polar to Cartesian
// Reduces the angle to [-pi/2, pi/2], scales the radius by the inverse CORDIC gain,
// runs one micro-rotation per cycle, then rounds and saturates to mm.
// ----------------------------------------------------------------------------
`default_nettype none

module lcx_cordic #(
   parameter int CORDIC_STAGES = lcx_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [lcx_pkg::ACC_W-1:0]    angle,
   input  wire logic        [lcx_pkg::RANGE_W-1:0]  radius,
   output logic                                     done,
   output logic signed      [lcx_pkg::COORD_W-1:0]  x_out,
   output logic signed      [lcx_pkg::COORD_W-1:0]  y_out
);
   import lcx_pkg::*;

   localparam int ITER_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STAGES - 1);

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_MUL   = 2'd1;
   localparam logic [1:0] C_ITER  = 2'd2;
   localparam logic [1:0] C_ROUND = 2'd3;

   localparam logic signed [CORDIC_W-1:0] ROUND_HALF = CORDIC_W'(1) <<< (FRAC - 1);

   logic [1:0]                  state_ff, state_in;
   logic [ITER_W-1:0]           iter_ff, iter_in;
   logic signed [ACC_W-1:0]     z_ff, z_in;
   logic signed [CORDIC_W-1:0]  x_ff, x_in;
   logic signed [CORDIC_W-1:0]  y_ff, y_in;
   logic                        flip_ff, flip_in;
   logic [RANGE_W-1:0]          rad_ff, rad_in;
   logic signed [COORD_W-1:0]   x_out_ff, x_out_in;
   logic signed [COORD_W-1:0]   y_out_ff, y_out_in;
   logic                        done_ff, done_in;

   logic signed [ACC_W-1:0]     wrap_ang;
   logic signed [ACC_W-1:0]     fold_ang;
   logic                        fold;
   logic [PROD_W-1:0]           prod;
   logic signed [CORDIC_W-1:0]  dx, dy;
   logic signed [ACC_W-1:0]     at;
   logic signed [CORDIC_W-1:0]  xr, yr;

   // bring the angle into one turn, then into the right half plane
   always_comb begin
      if (angle > PI_Q16) begin
         wrap_ang = angle - TWO_PI_Q16;
      end else if (angle < NEG_PI_Q16) begin
         wrap_ang = angle + TWO_PI_Q16;
      end else begin
         wrap_ang = angle;
      end
      if (wrap_ang > HALF_PI_Q16) begin
         fold_ang = wrap_ang - PI_Q16;
         fold     = 1'b1;
      end else if (wrap_ang < NEG_HALF_PI) begin
         fold_ang = wrap_ang + PI_Q16;
         fold     = 1'b1;
      end else begin
         fold_ang = wrap_ang;
         fold     = 1'b0;
      end
   end

   assign prod = PROD_W'(rad_ff) * PROD_W'(GAIN_Q30);
   assign dx   = x_ff >>> iter_ff;
   assign dy   = y_ff >>> iter_ff;
   assign at   = atan_q16(ATAN_IDX_W'(iter_ff));
   assign xr   = (x_ff + ROUND_HALF) >>> FRAC;
   assign yr   = (y_ff + ROUND_HALF) >>> FRAC;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      flip_in  = flip_ff;
      rad_in   = rad_ff;
      x_out_in = x_out_ff;
      y_out_in = y_out_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               z_in     = fold_ang;
               flip_in  = fold;
               rad_in   = radius;
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            x_in     = CORDIC_W'(prod >> GAIN_SHIFT);
            y_in     = '0;
            iter_in  = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (!z_ff[ACC_W-1]) begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               z_in = z_ff + at;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            x_out_in = sat_coord(flip_ff ? -xr : xr);
            y_out_in = sat_coord(flip_ff ? -yr : yr);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff  <= iter_in;
      z_ff     <= z_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      flip_ff  <= flip_in;
      rad_ff   <= rad_in;
      x_out_ff <= x_out_in;
      y_out_ff <= y_out_in;
   end

   assign done  = done_ff;
   assign x_out = x_out_ff;
   assign y_out = y_out_ff;

endmodule

`default_nettype wire
